// ===== hw/rtl/ssw_pkg.sv =====
// Shared types, constants and action codes for the session scheduler.
// No dependencies; imported by ssw_core and session_scheduler_with_watchdog.
package ssw_pkg;

  localparam int DEV_SLOTS           = 8;   // devices carried by the masks
  localparam int DEF_MAX_DEVICES     = 8;
  localparam int REG_IDX_W           = 2;
  localparam int CFG_DATA_W          = 22;

  localparam logic [21:0] DEF_SESSION_TIMEOUT = 22'd30000;
  localparam logic [19:0] DEF_ABORT_GRACE     = 20'd15000;
  localparam logic [15:0] DEF_SETTLE          = 16'd500;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_DEVICE_COUNT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_TIMEOUT      = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_GRACE        = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_SETTLE       = 2'd3;

  // action codes
  localparam logic [3:0] ACT_NONE        = 4'd0;
  localparam logic [3:0] ACT_ENDED       = 4'd1;
  localparam logic [3:0] ACT_GAVE_UP     = 4'd2;
  localparam logic [3:0] ACT_ABORT       = 4'd3;
  localparam logic [3:0] ACT_PRIO_START  = 4'd4;
  localparam logic [3:0] ACT_POLL_START  = 4'd5;
  localparam logic [3:0] ACT_BUSY_SKIP   = 4'd6;
  localparam logic [3:0] ACT_CYCLE_DONE  = 4'd7;
  localparam logic [3:0] ACT_CYCLE_REFUSE = 4'd8;
  localparam logic [3:0] ACT_CYCLE_START = 4'd9;

  localparam logic CMD_SERVICE = 1'b0;
  localparam logic CMD_CYCLE   = 1'b1;

  typedef struct packed {
    logic [3:0]  device_count;
    logic [21:0] session_timeout_ms;
    logic [19:0] grace_ms;
    logic [15:0] settle_ms;
  } cfg_t;

  typedef struct packed {
    logic        cmd;
    logic [31:0] now_ms;
    logic [7:0]  idle_mask;
    logic [7:0]  pending_mask;
  } item_t;

  typedef struct packed {
    logic [3:0] action;
    logic [2:0] device;
  } result_t;

endpackage

// ===== hw/rtl/ssw_core.sv =====
// Scheduler state registers and the per-word decision logic.
// Depends on ssw_pkg.
module ssw_core import ssw_pkg::*; #(
  parameter int MAX_DEVICES = DEF_MAX_DEVICES
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    fire,     // word in the input register is processed this cycle
  input  item_t   item,
  output result_t result
);

  localparam int CAP = (MAX_DEVICES < DEV_SLOTS) ? MAX_DEVICES : DEV_SLOTS;
  localparam logic [3:0] CAP_N = 4'(CAP);

  logic        session_active, session_active_next;
  logic [2:0]  active_index, active_index_next;
  logic [31:0] session_start_time, session_start_time_next;
  logic        abort_issued, abort_issued_next;
  logic [31:0] next_start_time, next_start_time_next;
  logic        cycle_running, cycle_running_next;
  logic [3:0]  poll_pointer, poll_pointer_next;

  logic [3:0]  n_used;
  logic [31:0] elapsed;
  logic [31:0] since_ready;
  logic [22:0] giveup_limit;
  logic [7:0]  cand;
  logic        prio_found;
  logic [2:0]  prio_idx;
  logic [2:0]  poll_idx;

  assign n_used       = (cfg.device_count > CAP_N) ? CAP_N : cfg.device_count;
  assign elapsed      = item.now_ms - session_start_time;
  assign since_ready  = item.now_ms - next_start_time;
  assign giveup_limit = {1'b0, cfg.session_timeout_ms} + {3'b0, cfg.grace_ms};
  assign poll_idx     = poll_pointer[2:0];

  // lowest idle device with a pending command, within the used count
  always_comb begin
    prio_found = 1'b0;
    prio_idx   = 3'd0;
    for (int i = 0; i < DEV_SLOTS; i++) begin
      cand[i] = item.idle_mask[i] & item.pending_mask[i] & (4'(i) < n_used);
    end
    for (int i = 0; i < DEV_SLOTS; i++) begin
      if (!prio_found && cand[i]) begin
        prio_found = 1'b1;
        prio_idx   = 3'(i);
      end
    end
  end

  always_comb begin
    session_active_next     = session_active;
    active_index_next       = active_index;
    session_start_time_next = session_start_time;
    abort_issued_next       = abort_issued;
    next_start_time_next    = next_start_time;
    cycle_running_next      = cycle_running;
    poll_pointer_next       = poll_pointer;
    result.action           = ACT_NONE;
    result.device           = 3'd0;

    if (item.cmd == CMD_CYCLE) begin
      if (n_used == 4'd0) begin
        result.action = ACT_NONE;
      end else if (cycle_running || session_active) begin
        result.action = ACT_CYCLE_REFUSE;
      end else begin
        poll_pointer_next  = 4'd0;
        cycle_running_next = 1'b1;
        result.action      = ACT_CYCLE_START;
      end
    end else if (session_active) begin
      result.device = active_index;
      if (item.idle_mask[active_index]) begin
        session_active_next  = 1'b0;
        next_start_time_next = item.now_ms + {16'd0, cfg.settle_ms};
        result.action        = ACT_ENDED;
      end else if (elapsed > {9'd0, giveup_limit}) begin
        session_active_next  = 1'b0;
        next_start_time_next = item.now_ms + {16'd0, cfg.settle_ms};
        result.action        = ACT_GAVE_UP;
      end else if (elapsed > {10'd0, cfg.session_timeout_ms} && !abort_issued) begin
        abort_issued_next = 1'b1;
        result.action     = ACT_ABORT;
      end else begin
        result.device = 3'd0;
      end
    end else if (!since_ready[31]) begin
      if (prio_found) begin
        session_active_next     = 1'b1;
        active_index_next       = prio_idx;
        session_start_time_next = item.now_ms;
        abort_issued_next       = 1'b0;
        result.action           = ACT_PRIO_START;
        result.device           = prio_idx;
      end else if (cycle_running) begin
        if (poll_pointer >= n_used) begin
          cycle_running_next = 1'b0;
          result.action      = ACT_CYCLE_DONE;
        end else begin
          poll_pointer_next = poll_pointer + 4'd1;
          result.device     = poll_idx;
          if (!item.idle_mask[poll_idx]) begin
            result.action = ACT_BUSY_SKIP;
          end else begin
            session_active_next     = 1'b1;
            active_index_next       = poll_idx;
            session_start_time_next = item.now_ms;
            abort_issued_next       = 1'b0;
            result.action           = ACT_POLL_START;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      session_active     <= 1'b0;
      active_index       <= 3'd0;
      session_start_time <= 32'd0;
      abort_issued       <= 1'b0;
      next_start_time    <= 32'd0;
      cycle_running      <= 1'b0;
      poll_pointer       <= 4'd0;
    end else if (fire) begin
      session_active     <= session_active_next;
      active_index       <= active_index_next;
      session_start_time <= session_start_time_next;
      abort_issued       <= abort_issued_next;
      next_start_time    <= next_start_time_next;
      cycle_running      <= cycle_running_next;
      poll_pointer       <= poll_pointer_next;
    end
  end

endmodule

// ===== hw/rtl/session_scheduler_with_watchdog.sv =====
// Top level: stream ports, configuration registers, input and result registers.
// Depends on ssw_pkg and ssw_core.
//
// Session scheduler with watchdog. Each input word (a service tick or a
// polling-cycle request) yields exactly one result word (action, device).
// A word is latched into an input register, decided by ssw_core against the
// scheduler state once the result register can take it, and lands in the
// result register; the block takes one word per cycle while results are read,
// and while a result waits it accepts only into an empty input register. The user
// must write configuration through wr_en/wr_index/wr_data only while idle; the block does not enforce it.
module session_scheduler_with_watchdog import ssw_pkg::*; #(
  parameter int MAX_DEVICES = DEF_MAX_DEVICES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [47:0]           s_axis_tdata,  // now_ms[31:0], idle_mask[39:32], pending_mask[47:40]
  input  logic                  s_axis_tuser,  // cmd
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [7:0]            m_axis_tdata,  // action[3:0], device[6:4], zero[7]
  input  logic                  wr_en,
  input  logic [REG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data
);

  cfg_t    cfg;
  item_t   in_item;
  logic    in_valid;
  result_t out_res;
  result_t core_res;
  logic    out_valid;
  logic    advance;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_res.device, out_res.action};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_count       <= 4'd0;
      cfg.session_timeout_ms <= DEF_SESSION_TIMEOUT;
      cfg.grace_ms           <= DEF_ABORT_GRACE;
      cfg.settle_ms          <= DEF_SETTLE;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_DEVICE_COUNT: cfg.device_count       <= wr_data[3:0];
        REG_TIMEOUT:      cfg.session_timeout_ms <= wr_data[21:0];
        REG_GRACE:        cfg.grace_ms           <= wr_data[19:0];
        REG_SETTLE:       cfg.settle_ms          <= wr_data[15:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item.cmd          <= s_axis_tuser;
      in_item.now_ms       <= s_axis_tdata[31:0];
      in_item.idle_mask    <= s_axis_tdata[39:32];
      in_item.pending_mask <= s_axis_tdata[47:40];
    end
  end

  ssw_core #(
    .MAX_DEVICES (MAX_DEVICES)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .fire   (advance),
    .item   (in_item),
    .result (core_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= core_res;
    end
  end

endmodule
